// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the stencil sweep.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/fps_pkg.sv =====
// Shared types, constants and helpers of the five-point stencil sweep.
`timescale 1ns / 1ps
`default_nettype none
package fps_pkg;

  localparam int MAX_SIDE    = 1024;
  localparam int VALUE_W     = 32;
  localparam int COORD_W     = 10;
  localparam int SIDE_W      = 11;
  localparam int GAIN_W      = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 56;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [SIDE_W-1:0] MIN_SIDE_V = SIDE_W'(3);
  localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);

  localparam logic [MODE_W-1:0] MODE_LAPLACIAN    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JACOBI       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GAUSS_SEIDEL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RICHARDSON   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_GAIN = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(1024);
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_JACOBI;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6554);

  // Position and result flags of one job.
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               has_first;
    logic               has_second;
    logic               inner;
    logic               done;
  } pos_t;

  // Work item handed from the front end to the back end.
  typedef struct packed {
    pos_t                      pos;
    logic signed [VALUE_W-1:0] ctr;
    logic signed [VALUE_W-1:0] up_old;
    logic signed [VALUE_W-1:0] lf_old;
    logic signed [VALUE_W-1:0] rt;
    logic signed [VALUE_W-1:0] bp;
    logic signed [VALUE_W-1:0] x;
    logic signed [VALUE_W-1:0] b;
  } job_t;

  function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat_value = VALUE_W'(hi);
    end else if (v < lo) begin
      sat_value = VALUE_W'(lo);
    end else begin
      sat_value = VALUE_W'(v);
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fps_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module fps_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_b_i,
  output logic      [WIDTH-1:0]         rd_a_o,
  output logic      [WIDTH-1:0]         rd_b_o,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Reads return the contents from before a same-cycle write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_a_o <= mem[addr_a_i];
      rd_b_o <= mem[addr_b_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fps_queue.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module fps_queue import fps_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire job_t              job_i,
  input  wire logic              pop_i,
  output job_t                   head_o,
  output logic                   empty_o,
  output logic [QCNT_W-1:0]      count_o
);

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign head_o  = slot_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = push_i ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fps_front.sv =====
// Front end: input handshake, raster counters, old-row and rhs line buffers.
`timescale 1ns / 1ps
`default_nettype none
module fps_front import fps_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic signed [VALUE_W-1:0] x_i,
  input  wire logic signed [VALUE_W-1:0] b_i,
  input  wire logic [SIDE_W-1:0]        grid_side_i,
  input  wire logic [QCNT_W-1:0]        q_count_i,
  output logic                          push_o,
  output job_t                          job_o
);

  logic [COORD_W-1:0] row_q, row_d;
  logic [COORD_W-1:0] col_q, col_d;
  logic [SIDE_W-1:0]  side;
  logic [SIDE_W-1:0]  r0, c0, c1, r1;
  logic [COORD_W-1:0] r, c;
  logic               accept;
  logic [QCNT_W:0]    need;

  logic               jv_q;
  logic               cur_q;
  pos_t               pos_q;
  pos_t               pos_d;
  logic signed [VALUE_W-1:0] x_q, b_q;
  logic signed [VALUE_W-1:0] prev_ctr_q;

  logic [VALUE_W-1:0] b0_a, b0_b, b1_a, b1_b, rhs_a, rhs_b_unused;

  always_comb begin
    if (grid_side_i < MIN_SIDE_V) begin
      side = MIN_SIDE_V;
    end else if (grid_side_i > MAX_SIDE_V) begin
      side = MAX_SIDE_V;
    end else begin
      side = grid_side_i;
    end
  end

  assign need    = {1'b0, q_count_i} + (QCNT_W+1)'(jv_q);
  assign ready_o = (need < (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept  = valid_i && ready_o;

  always_comb begin
    c0 = {1'b0, col_q};
    r0 = {1'b0, row_q};
    if (c0 >= side) begin
      c0 = '0;
      r0 = r0 + SIDE_W'(1);
    end
    if (r0 >= side) begin
      r0 = '0;
    end
    r  = r0[COORD_W-1:0];
    c  = c0[COORD_W-1:0];
    c1 = c0 + SIDE_W'(1);
    r1 = r0 + SIDE_W'(1);
    if (c1 >= side) begin
      col_d = '0;
      row_d = (r1 >= side) ? '0 : r1[COORD_W-1:0];
    end else begin
      col_d = c1[COORD_W-1:0];
      row_d = r;
    end
    pos_d.row        = r;
    pos_d.col        = c;
    pos_d.has_first  = (r != '0);
    pos_d.has_second = (r0 == side - SIDE_W'(1));
    pos_d.inner      = (r >= COORD_W'(2)) && (c != '0) && (c1 < side);
    pos_d.done       = (c0 == side - SIDE_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      jv_q  <= 1'b0;
    end else begin
      jv_q <= accept;
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= pos_d;
      cur_q <= r[0];
      x_q   <= x_i;
      b_q   <= b_i;
    end
    if (jv_q) begin
      prev_ctr_q <= job_o.ctr;
    end
  end

  // Even rows live in bank 0 and odd rows in bank 1.
  fps_ram #(.DEPTH(MAX_SIDE), .WIDTH(VALUE_W)) u_bank0 (
    .clk_i    (clk_i),
    .re_i     (accept),
    .addr_a_i (c),
    .addr_b_i (c + COORD_W'(1)),
    .rd_a_o   (b0_a),
    .rd_b_o   (b0_b),
    .we_i     (accept && !r[0]),
    .waddr_i  (c),
    .wdata_i  (x_i)
  );

  fps_ram #(.DEPTH(MAX_SIDE), .WIDTH(VALUE_W)) u_bank1 (
    .clk_i    (clk_i),
    .re_i     (accept),
    .addr_a_i (c),
    .addr_b_i (c + COORD_W'(1)),
    .rd_a_o   (b1_a),
    .rd_b_o   (b1_b),
    .we_i     (accept && r[0]),
    .waddr_i  (c),
    .wdata_i  (x_i)
  );

  fps_ram #(.DEPTH(MAX_SIDE), .WIDTH(VALUE_W)) u_rhs (
    .clk_i    (clk_i),
    .re_i     (accept),
    .addr_a_i (c),
    .addr_b_i (c),
    .rd_a_o   (rhs_a),
    .rd_b_o   (rhs_b_unused),
    .we_i     (accept),
    .waddr_i  (c),
    .wdata_i  (b_i)
  );

  always_comb begin
    job_o.pos    = pos_q;
    job_o.ctr    = cur_q ? b0_a : b1_a;
    job_o.rt     = cur_q ? b0_b : b1_b;
    job_o.up_old = cur_q ? b1_a : b0_a;
    job_o.lf_old = prev_ctr_q;
    job_o.bp     = rhs_a;
    job_o.x      = x_q;
    job_o.b      = b_q;
  end

  assign push_o = jv_q && (pos_q.has_first || pos_q.has_second);

endmodule
`default_nettype wire

// ===== hdl/fps_back.sv =====
// Back end: stencil arithmetic, updated-row buffer and result beats.
`timescale 1ns / 1ps
`default_nettype none
module fps_back import fps_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire job_t                head_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [GAIN_W-1:0]   gain_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic [COORD_W-1:0]       row_o,
  output logic [COORD_W-1:0]       col_o,
  output logic                     last_o,
  output logic                     done_o
);

  logic adv;
  logic last_beat;
  logic second_shown;

  // Stage 1: arithmetic on the popped job.
  logic  s1_v_q;
  job_t  s1_q;
  logic [VALUE_W-1:0] upnew;
  logic [VALUE_W-1:0] upnew_unused;
  logic signed [VALUE_W-1:0] left_q;

  logic signed [VALUE_W-1:0] u, l, v1_s1, v2_s1;
  logic signed [35:0] sum4, lap, jsum;
  logic signed [36:0] lapb;
  logic signed [32:0] negb;
  logic               gs;

  // Stage 2: products.
  logic s2_v_q;
  pos_t s2_pos_q;
  logic signed [VALUE_W-1:0] s2_ctr_q, s2_x_q, s2_v1_q, s2_v2_q;
  logic signed [36:0] s2_lapb_q;
  logic signed [32:0] s2_negb_q;

  // Stage 3: rounding of the Richardson correction.
  logic s3_v_q;
  pos_t s3_pos_q;
  logic signed [VALUE_W-1:0] s3_ctr_q, s3_x_q, s3_v1_q, s3_v2_q;
  logic signed [53:0] s3_p1_q;
  logic signed [49:0] s3_p2_q;
  logic signed [53:0] q1;
  logic signed [49:0] q2;
  logic signed [VALUE_W-1:0] rich1, rich2, v1_s3, v2_s3;

  // Stage 4: output register.
  logic s4_v_q;
  pos_t s4_pos_q;
  logic s4_sel_q;
  logic signed [VALUE_W-1:0] s4_v1_q, s4_v2_q;

  logic nr_we;
  logic [COORD_W-1:0] nr_addr;
  logic signed [VALUE_W-1:0] nr_data;

  assign second_shown = !s4_pos_q.has_first || s4_sel_q;
  assign last_beat    = second_shown || !s4_pos_q.has_second;
  assign adv          = !s4_v_q || (ready_i && last_beat);
  assign pop_o        = adv && !empty_i;

  assign gs = (mode_i == MODE_GAUSS_SEIDEL);

  always_comb begin
    u     = gs ? $signed(upnew) : s1_q.up_old;
    l     = gs ? left_q : s1_q.lf_old;
    sum4  = 36'(u) + 36'(s1_q.x) + 36'(l) + 36'(s1_q.rt);
    lap   = s1_q.pos.inner ? (36'(s1_q.ctr) <<< 2) - sum4 : '0;
    jsum  = sum4 + 36'(s1_q.bp) + 36'sd2;
    lapb  = 37'(lap) - 37'(s1_q.bp);
    negb  = -33'(s1_q.b);
    case (mode_i)
      MODE_LAPLACIAN: begin
        v1_s1 = sat_value(64'(lap));
        v2_s1 = '0;
      end
      MODE_JACOBI, MODE_GAUSS_SEIDEL: begin
        v1_s1 = s1_q.pos.inner ? sat_value(64'(jsum >>> 2)) : s1_q.ctr;
        v2_s1 = s1_q.x;
      end
      default: begin
        v1_s1 = '0;
        v2_s1 = '0;
      end
    endcase
  end

  always_comb begin
    q1    = (s3_p1_q + 54'sd32768) >>> 16;
    q2    = (s3_p2_q + 50'sd32768) >>> 16;
    rich1 = sat_value(64'(s3_ctr_q) - 64'(q1));
    rich2 = sat_value(64'(s3_x_q) - 64'(q2));
    v1_s3 = (mode_i == MODE_RICHARDSON) ? rich1 : s3_v1_q;
    v2_s3 = (mode_i == MODE_RICHARDSON) ? rich2 : s3_v2_q;
  end

  // Updated values feed the upper and left neighbors of Gauss-Seidel.
  always_comb begin
    if (mode_i == MODE_RICHARDSON) begin
      nr_we   = adv && s3_v_q && s3_pos_q.has_first;
      nr_addr = s3_pos_q.col;
      nr_data = rich1;
    end else begin
      nr_we   = adv && s1_v_q && s1_q.pos.has_first;
      nr_addr = s1_q.pos.col;
      nr_data = v1_s1;
    end
  end

  fps_ram #(.DEPTH(MAX_SIDE), .WIDTH(VALUE_W)) u_new_row (
    .clk_i    (clk_i),
    .re_i     (pop_o),
    .addr_a_i (head_i.pos.col),
    .addr_b_i (head_i.pos.col),
    .rd_a_o   (upnew),
    .rd_b_o   (upnew_unused),
    .we_i     (nr_we),
    .waddr_i  (nr_addr),
    .wdata_i  (nr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      s4_v_q   <= 1'b0;
      s4_sel_q <= 1'b0;
      left_q   <= '0;
    end else begin
      if (nr_we) begin
        left_q <= nr_data;
      end
      if (adv) begin
        s1_v_q   <= !empty_i;
        s2_v_q   <= s1_v_q;
        s3_v_q   <= s2_v_q;
        s4_v_q   <= s3_v_q;
        s4_sel_q <= 1'b0;
      end else if (ready_i) begin
        s4_sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q      <= head_i;
      s2_pos_q  <= s1_q.pos;
      s2_ctr_q  <= s1_q.ctr;
      s2_x_q    <= s1_q.x;
      s2_v1_q   <= v1_s1;
      s2_v2_q   <= v2_s1;
      s2_lapb_q <= lapb;
      s2_negb_q <= negb;
      s3_pos_q  <= s2_pos_q;
      s3_ctr_q  <= s2_ctr_q;
      s3_x_q    <= s2_x_q;
      s3_v1_q   <= s2_v1_q;
      s3_v2_q   <= s2_v2_q;
      s3_p1_q   <= 54'(s2_lapb_q) * 54'($signed({1'b0, gain_i}));
      s3_p2_q   <= 50'(s2_negb_q) * 50'($signed({1'b0, gain_i}));
      s4_pos_q  <= s3_pos_q;
      s4_v1_q   <= v1_s3;
      s4_v2_q   <= v2_s3;
    end
  end

  assign valid_o = s4_v_q;
  assign value_o = second_shown ? s4_v2_q : s4_v1_q;
  assign row_o   = second_shown ? s4_pos_q.row : s4_pos_q.row - COORD_W'(1);
  assign col_o   = s4_pos_q.col;
  assign last_o  = last_beat;
  assign done_o  = second_shown && s4_pos_q.done;

endmodule
`default_nettype wire

// ===== hdl/five_point_stencil_sweep.sv =====
// Top level of the five-point stencil sweep: config registers and the front/back split.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// One raster-order pass of the 5-point Poisson stencil over an N by N grid, with N set
// by grid_side (clamped to 3..1024). Each input beat carries x and b of one point in
// signed Q15.16; results come out one row late, so row 0 produces nothing and every
// point of the last row produces two beats (the pending point of the row above, then
// the boundary point itself). sweep_mode picks Laplacian, Jacobi, in-place Gauss-Seidel
// or Richardson with gain inverse_gain; all results saturate to 32 bits. The block takes
// one input beat per clock and gives one result beat per clock while the output is not
// stalled; during the last row the output port is the limit, as each input beat there
// yields two result beats. The front end keeps the two previous input rows in two
// single-row RAM banks and the previous rhs row in a third RAM; the back end holds the
// updated previous row for Gauss-Seidel in a fourth RAM and runs a four-stage pipeline
// (stencil sums, gain multiply, rounding, output register). A four-entry job queue lets
// each side stall alone. The RAMs need no clearing after reset. The user must write
// configuration only while no results are outstanding; the block does not enforce it.
module five_point_stencil_sweep import fps_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // x_value[31:0], b_value[63:32]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // result_value, out_row, out_col, 0
  output logic                       m_axis_tlast,  // last_of_run
  output logic                       m_axis_tuser,  // grid_done
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SIDE_W-1:0] grid_side_q;
  logic [MODE_W-1:0] mode_q;
  logic [GAIN_W-1:0] gain_q;

  logic              push;
  job_t              job;
  job_t              head;
  logic              empty;
  logic              pop;
  logic [QCNT_W-1:0] q_count;

  logic signed [VALUE_W-1:0] value;
  logic [COORD_W-1:0]        out_row;
  logic [COORD_W-1:0]        out_col;

  // Register writes take effect at once; index three is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= SIDE_RESET;
      mode_q      <= MODE_RESET;
      gain_q      <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_SIDE:    grid_side_q <= cfg_data_i[SIDE_W-1:0];
        REG_SWEEP_MODE:   mode_q      <= cfg_data_i[MODE_W-1:0];
        REG_INVERSE_GAIN: gain_q      <= cfg_data_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .x_i         (s_axis_tdata[31:0]),
    .b_i         (s_axis_tdata[63:32]),
    .grid_side_i (grid_side_q),
    .q_count_i   (q_count),
    .push_o      (push),
    .job_o       (job)
  );

  fps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .count_o (q_count)
  );

  fps_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .mode_i  (mode_q),
    .gain_i  (gain_q),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .value_o (value),
    .row_o   (out_row),
    .col_o   (out_col),
    .last_o  (m_axis_tlast),
    .done_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0, out_col, out_row, value};

  // The queue never takes a job while full.
  `ASSERT_ALWAYS(a_queue_bound, clk_i, rst_ni, q_count <= QCNT_W'(QUEUE_DEPTH))
  `ASSERT_IMPLIES(a_push_room, clk_i, rst_ni, push && !pop, q_count < QCNT_W'(QUEUE_DEPTH))
  // The final grid point ends its run and sits on the diagonal.
  `ASSERT_IMPLIES(a_done_last, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                  m_axis_tlast && (out_row == out_col))

endmodule
`default_nettype wire

// ===== dv/tb_five_point_stencil_sweep.sv =====
// Self-checking testbench for the five-point stencil sweep block.
`timescale 1ns / 1ps
module tb_five_point_stencil_sweep;
  import fps_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_WAIT     = 16;
  localparam int RAND_ITEMS     = 1050;
  localparam int BIG_GRID_ITEMS = 30 * 30;

  // One expected output beat of the sweep.
  typedef struct {
    logic [31:0] value;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
    logic        done;
  } point_beat_t;

  // Mirrors the sweep state and keeps the beats still owed by the block.
  class sweep_scoreboard;
    logic [31:0] old_rows [2*MAX_SIDE];
    logic [31:0] new_row [MAX_SIDE];
    logic [31:0] rhs_row [MAX_SIDE];
    longint      left_new;
    int          row_cnt;
    int          col_cnt;
    int          side_reg;
    int          mode_reg;
    int          gain_reg;
    point_beat_t owed_beats[$];
    int          errors;

    function new();
      side_reg = 1024;
      mode_reg = 1;
      gain_reg = 6554;
      left_new = 0;
      row_cnt  = 0;
      col_cnt  = 0;
      errors   = 0;
    endfunction

    function void set_reg(int idx, int val);
      if (idx == REG_GRID_SIDE) begin
        side_reg = val & 'h7FF;
      end else if (idx == REG_SWEEP_MODE) begin
        mode_reg = val & 3;
      end else if (idx == REG_INVERSE_GAIN) begin
        gain_reg = val & 'hFFFF;
      end
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint sx(logic [31:0] v);
      return longint'($signed(v));
    endfunction

    // Value of one emitted point under the current mode.
    function longint stencil_point(bit inner, longint c, longint u, longint d, longint l,
                                   longint r, longint b);
      longint lap;
      lap = inner ? 4 * c - (u + d + l + r) : 0;
      if (mode_reg == MODE_LAPLACIAN) return clip32(lap);
      if (mode_reg == MODE_RICHARDSON)
        return clip32(c - (((lap - b) * longint'(gain_reg) + 32768) >>> 16));
      if (!inner) return clip32(c);
      return clip32((u + d + l + r + b + 2) >>> 2);
    endfunction

    // Accepted input beat: advance the raster position and queue its results.
    function void note_point(logic [31:0] x, logic [31:0] b);
      int side, r, c, cur, prv;
      bit inner, gs;
      longint up, lf, rt, v;
      point_beat_t fresh [2];
      int n;
      n = 0;
      side = side_reg < 3 ? 3 : (side_reg > MAX_SIDE ? MAX_SIDE : side_reg);
      if (col_cnt >= side) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= side) row_cnt = 0;
      r = row_cnt;
      c = col_cnt;
      cur = (r & 1) * MAX_SIDE;
      prv = ((r + 1) & 1) * MAX_SIDE;
      if (r >= 1) begin
        inner = (r - 1 >= 1) && (c >= 1) && (c + 1 < side);
        up = 0;
        lf = 0;
        rt = 0;
        if (inner) begin
          gs = (mode_reg == MODE_GAUSS_SEIDEL);
          up = gs ? sx(new_row[c]) : sx(old_rows[cur + c]);
          lf = gs ? left_new : sx(old_rows[prv + c - 1]);
          rt = sx(old_rows[prv + c + 1]);
        end
        v = stencil_point(inner, sx(old_rows[prv + c]), up, sx(x), lf, rt, sx(rhs_row[c]));
        new_row[c] = v[31:0];
        left_new = v;
        fresh[n] = '{v[31:0], 10'(r - 1), 10'(c), 1'b0, 1'b0};
        n++;
      end
      old_rows[cur + c] = x;
      rhs_row[c] = b;
      // The final row is also emitted as it arrives, all of it boundary.
      if (r == side - 1) begin
        v = stencil_point(1'b0, sx(x), 0, 0, 0, 0, sx(b));
        fresh[n] = '{v[31:0], 10'(r), 10'(c), 1'b0, c == side - 1};
        n++;
      end
      if (n > 0) fresh[n - 1].last = 1'b1;
      for (int k = 0; k < n; k++) owed_beats.insert(owed_beats.size(), fresh[k]);
      col_cnt = c + 1;
      if (col_cnt >= side) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= side) ? 0 : r + 1;
      end
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] data, logic last, logic done);
      point_beat_t e;
      if (owed_beats.size() == 0) begin
        $display("%0t: unexpected beat data=%h last=%b done=%b", $time, data, last, done);
        errors++;
        return;
      end
      e = owed_beats.pop_front();
      if (data[31:0] !== e.value || data[41:32] !== e.row || data[51:42] !== e.col ||
          data[55:52] !== 4'd0 || last !== e.last || done !== e.done) begin
        $display("%0t: mismatch expected val=%h row=%0d col=%0d last=%b done=%b",
                 $time, e.value, e.row, e.col, e.last, e.done);
        $display("%0t:          actual   val=%h row=%0d col=%0d last=%b done=%b pad=%h",
                 $time, data[31:0], data[41:32], data[51:42], last, done, data[55:52]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sweep_scoreboard sweep_sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  sent_items = 0;
  int  cycle_cnt = 0;

  five_point_stencil_sweep i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake must not run forever.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check every accepted beat, then pick the next ready level at random.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sweep_sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Values lean on the saturation corners but still span every bit pattern.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(2**21)) - 2**20);
    endcase
  endfunction

  // Drive one input beat; tvalid stays high afterward unless the next beat idles first.
  task automatic send_point(input logic [31:0] x, input logic [31:0] b);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, x};
    do @(posedge clk_i); while (!s_axis_tready);
    sweep_sb.note_point(x, b);
    sent_items++;
  endtask

  // Hold the sender until nothing is owed, then give the pipeline time to settle.
  task automatic wait_idle();
    while (sweep_sb.owed_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Register writes only happen here, with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    s_axis_tvalid <= 1'b0;
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sweep_sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // A full grid leaves the raster position back at the origin for the next setting.
  task automatic run_grid(input int side);
    int eff;
    eff = side < 3 ? 3 : side;
    for (int r = 0; r < eff; r++) begin
      // Now and then switch the mode at a row boundary.
      if (r > 1 && $urandom_range(9) == 0) begin
        write_reg(REG_SWEEP_MODE, $urandom_range(3));
      end
      for (int c = 0; c < eff; c++) begin
        send_point(pick_value(), pick_value());
      end
    end
  endtask

  initial begin
    int side;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The largest side register value clamps to the maximum side;
    // feed a few first-row points, then shrink the side so the sweep wraps early.
    write_reg(REG_GRID_SIDE, 2047);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h0000_0000, 32'hFFFF_FFFF);
    write_reg(REG_GRID_SIDE, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0001_0000, 32'hFFFF_0000);
    send_point(32'hFFFF_FFFF, 32'h0000_0001);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    // Laplacian with saturating sums, then Richardson at the largest gain.
    write_reg(REG_SWEEP_MODE, MODE_LAPLACIAN);
    write_reg(REG_GRID_SIDE, 3);
    for (int k = 0; k < 9; k++) begin
      send_point((k == 4) ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h7FFF_FFFF);
    end
    write_reg(REG_SWEEP_MODE, MODE_RICHARDSON);
    write_reg(REG_INVERSE_GAIN, 65535);
    run_grid(3);
    write_reg(REG_INVERSE_GAIN, 0);

    // Random grids, with the idling profile moving through three phases.
    while (sent_items < RAND_ITEMS) begin
      if (sent_items < RAND_ITEMS / 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 48;
      end else if (sent_items < 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Large grids only while one of them still fits in the item budget.
      side = (sent_items + BIG_GRID_ITEMS <= RAND_ITEMS && $urandom_range(9) == 0) ?
             $urandom_range(13, 30) : $urandom_range(0, 8);
      write_reg(REG_GRID_SIDE, side);
      write_reg(REG_SWEEP_MODE, $urandom_range(3));
      case ($urandom_range(3))
        0: write_reg(REG_INVERSE_GAIN, 0);
        1: write_reg(REG_INVERSE_GAIN, 65535);
        default: write_reg(REG_INVERSE_GAIN, $urandom_range(65535));
      endcase
      run_grid(side);
    end

    s_axis_tvalid <= 1'b0;
    wait_idle();
    if (sweep_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
